// ===== rtl/lbba_pkg.sv =====
// Shared types, register codes and constants of the LED blink and breathe animator.
package lbba_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int NOW_W          = 32;
	localparam int LEVEL_W        = 8;
	localparam int RATE_W         = 16;
	localparam int MODE_W         = 2;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 16;
	localparam int KEY_W          = 4 * LEVEL_W;
	// operand width of the short divide (ramp scale)
	localparam int SHORT_DIV_W    = 24;

	localparam logic [LEVEL_W-1:0] FULL_SCALE = 8'd255;

	typedef enum logic [MODE_W-1:0] {
		MODE_OFF     = 2'd0,
		MODE_SOLID   = 2'd1,
		MODE_BLINK   = 2'd2,
		MODE_BREATHE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_RED    = 3'd1,
		REG_GREEN  = 3'd2,
		REG_BLUE   = 3'd3,
		REG_RATE   = 3'd4,
		REG_BASE   = 3'd5
	} reg_idx_t;

	localparam mode_t               RST_MODE  = MODE_BLINK;
	localparam logic [LEVEL_W-1:0]  RST_RED   = 8'd0;
	localparam logic [LEVEL_W-1:0]  RST_GREEN = 8'd0;
	localparam logic [LEVEL_W-1:0]  RST_BLUE  = 8'd255;
	localparam logic [RATE_W-1:0]   RST_RATE  = 16'd500;
	localparam logic [LEVEL_W-1:0]  RST_BASE  = 8'd64;

	typedef struct packed {
		mode_t               mode;
		logic [LEVEL_W-1:0]  red;
		logic [LEVEL_W-1:0]  green;
		logic [LEVEL_W-1:0]  blue;
		logic [RATE_W-1:0]   rate;
		logic [LEVEL_W-1:0]  base;
	} cfg_t;

	typedef struct packed {
		logic start;
		logic short_op;
	} div_ctl_t;

	typedef struct packed {
		logic done;
	} div_sts_t;

endpackage

// ===== rtl/lbba_tick_if.sv =====
// Render tick channel: valid, ready and the millisecond time.
interface lbba_tick_if import lbba_pkg::*;;
	logic             valid;
	logic             ready;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, output now_ms, input ready);
	modport sink (input valid, input now_ms, output ready);
endinterface

// ===== rtl/lbba_pix_if.sv =====
// Result channel: valid, ready, colour and effective brightness.
interface lbba_pix_if import lbba_pkg::*;;
	logic               valid;
	logic               ready;
	logic [LEVEL_W-1:0] out_red;
	logic [LEVEL_W-1:0] out_green;
	logic [LEVEL_W-1:0] out_blue;
	logic [LEVEL_W-1:0] out_brightness;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_brightness, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_brightness, output ready);
endinterface

// ===== rtl/lbba_cfg_if.sv =====
// Configuration write channel: valid, ready, register index and write data.
interface lbba_cfg_if import lbba_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/lbba_cfg_regs.sv =====
// Configuration register file with restart strobe on every known write.
module lbba_cfg_regs import lbba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lbba_cfg_if.sink   cfg,
	output cfg_t       regs,
	output logic       cfg_hit
);

	cfg_t     regs_q;
	logic     wr_beat;
	reg_idx_t idx;

	assign cfg.ready = 1'b1;
	assign wr_beat   = cfg.valid && cfg.ready;
	assign idx       = reg_idx_t'(cfg.index);
	assign regs      = regs_q;

	// flag a write to a listed register
	always_comb begin
		unique case (idx)
			REG_MODE, REG_RED, REG_GREEN, REG_BLUE, REG_RATE, REG_BASE: cfg_hit = wr_beat;
			default: cfg_hit = 1'b0;
		endcase
	end

	// hold the registers, update on a write beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode  <= RST_MODE;
			regs_q.red   <= RST_RED;
			regs_q.green <= RST_GREEN;
			regs_q.blue  <= RST_BLUE;
			regs_q.rate  <= RST_RATE;
			regs_q.base  <= RST_BASE;
		end else if (wr_beat) begin
			unique case (idx)
				REG_MODE:  regs_q.mode  <= mode_t'(cfg.data[MODE_W-1:0]);
				REG_RED:   regs_q.red   <= cfg.data[LEVEL_W-1:0];
				REG_GREEN: regs_q.green <= cfg.data[LEVEL_W-1:0];
				REG_BLUE:  regs_q.blue  <= cfg.data[LEVEL_W-1:0];
				REG_RATE:  regs_q.rate  <= cfg.data[RATE_W-1:0];
				REG_BASE:  regs_q.base  <= cfg.data[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/lbba_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module lbba_div import lbba_pkg::*; #(
	parameter int DIV_W = SHORT_DIV_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  div_ctl_t          div_ctl,
	input  logic [DIV_W-1:0]  div_dvd,
	input  logic [RATE_W-1:0] div_dsr,
	output div_sts_t          div_sts,
	output logic [DIV_W-1:0]  div_quo,
	output logic [RATE_W-1:0] div_rem
);

	localparam int CNT_W = $clog2(DIV_W + 1);
	localparam int ALIGN = DIV_W - SHORT_DIV_W;

	logic [DIV_W-1:0]  dvd_q;
	logic [DIV_W-1:0]  quo_q;
	logic [RATE_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic              busy;
	logic [RATE_W:0]   trial;
	logic              fits;
	logic [RATE_W:0]   trial_sub;

	assign busy      = cnt_q != '0;
	assign trial     = {rem_q, dvd_q[DIV_W-1]};
	assign fits      = trial >= {1'b0, div_dsr};
	assign trial_sub = trial - {1'b0, div_dsr};

	assign div_sts.done = done_q;
	assign div_quo      = quo_q;
	assign div_rem      = rem_q;

	// load operands, then shift and subtract once per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
			dvd_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= busy && (cnt_q == CNT_W'(1));
			if (div_ctl.start) begin
				cnt_q <= div_ctl.short_op ? CNT_W'(SHORT_DIV_W) : CNT_W'(DIV_W);
				dvd_q <= div_ctl.short_op ? (div_dvd << ALIGN) : div_dvd;
				quo_q <= '0;
				rem_q <= '0;
			end else if (busy) begin
				cnt_q <= cnt_q - CNT_W'(1);
				dvd_q <= dvd_q << 1;
				quo_q <= {quo_q[DIV_W-2:0], fits};
				rem_q <= fits ? trial_sub[RATE_W-1:0] : trial[RATE_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/lbba_seq.sv =====
// Tick sequencer: animation state, mode evaluation, change filter and output register.
module lbba_seq import lbba_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF,
	parameter int DIV_W      = SHORT_DIV_W
) (
	input  logic              clk,
	input  logic              arst_n,
	lbba_tick_if.sink         tick,
	lbba_pix_if.source        pix,
	input  cfg_t              regs,
	input  logic              cfg_hit,
	output div_ctl_t          div_ctl,
	output logic [DIV_W-1:0]  div_dvd,
	output logic [RATE_W-1:0] div_dsr,
	input  div_sts_t          div_sts,
	input  logic [DIV_W-1:0]  div_quo,
	input  logic [RATE_W-1:0] div_rem
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b000_0001,
		ST_EVAL  = 7'b000_0010,
		ST_MOD   = 7'b000_0100,
		ST_RAMP  = 7'b000_1000,
		ST_SCALE = 7'b001_0000,
		ST_PROD  = 7'b010_0000,
		ST_EMIT  = 7'b100_0000
	} state_t;

	state_t                  state_q;
	logic [TIME_WIDTH-1:0]   now_q;
	logic [TIME_WIDTH-1:0]   anim_q;
	logic [TIME_WIDTH-1:0]   toggle_q;
	logic                    blink_q;
	logic                    pending_q;
	logic                    shown_q;
	logic [KEY_W-1:0]        last_q;
	logic [LEVEL_W-1:0]      br_q;
	logic [RATE_W-1:0]       up_q;
	logic [LEVEL_W-1:0]      scale_q;
	logic [DIV_W-1:0]        dvd_q;
	logic [RATE_W-1:0]       dsr_q;
	logic                    start_q;
	logic                    short_q;
	logic                    out_valid_q;
	logic [LEVEL_W-1:0]      out_red_q;
	logic [LEVEL_W-1:0]      out_green_q;
	logic [LEVEL_W-1:0]      out_blue_q;
	logic [LEVEL_W-1:0]      out_br_q;

	logic                    in_beat;
	logic [TIME_WIDTH-1:0]   now_in;
	logic [RATE_W-1:0]       period;
	logic [RATE_W-1:0]       half;
	logic [TIME_WIDTH-1:0]   since_toggle;
	logic [TIME_WIDTH-1:0]   elapsed;
	logic                    blink_due;
	logic                    blink_next;
	logic [RATE_W-1:0]       up_next;
	logic [SHORT_DIV_W-1:0]  ramp_prod;
	logic [2*LEVEL_W-1:0]    dim_prod;
	logic [2*LEVEL_W-1:0]    dim_sum;
	logic [LEVEL_W-1:0]      dim_quo;
	logic [LEVEL_W-1:0]      scale_sat;
	logic [KEY_W-1:0]        key;
	logic                    is_new;
	logic                    out_free;

	assign tick.ready = state_q == ST_IDLE;
	assign in_beat    = tick.valid && tick.ready;
	assign now_in     = TIME_WIDTH'(tick.now_ms);

	// period of zero acts as one
	assign period       = (regs.rate == '0) ? RATE_W'(1) : regs.rate;
	assign half         = period >> 1;
	assign since_toggle = now_q - toggle_q;
	assign elapsed      = now_q - anim_q;
	assign blink_due    = since_toggle >= TIME_WIDTH'(period);
	assign blink_next   = blink_due ? !blink_q : blink_q;

	// fold the phase into the rising side of the triangle
	assign up_next   = (div_rem < half) ? div_rem : period - div_rem;
	assign ramp_prod = (SHORT_DIV_W'(up_q) << LEVEL_W) - SHORT_DIV_W'(up_q);
	assign dim_prod  = regs.base * scale_q;
	assign scale_sat = (div_quo[SHORT_DIV_W-1:0] > SHORT_DIV_W'(FULL_SCALE)) ?
		FULL_SCALE : div_quo[LEVEL_W-1:0];

	// divide the dimmed product by full scale: (x + (x >> 8) + 1) >> 8, exact up to 255*255
	assign dim_sum = dim_prod + (dim_prod >> LEVEL_W) + (2*LEVEL_W)'(1);
	assign dim_quo = dim_sum[2*LEVEL_W-1:LEVEL_W];

	assign key      = {br_q, regs.red, regs.green, regs.blue};
	assign is_new   = !shown_q || (key != last_q);
	assign out_free = !out_valid_q || pix.ready;

	assign div_ctl.start    = start_q;
	assign div_ctl.short_op = short_q;
	assign div_dvd          = dvd_q;
	assign div_dsr          = dsr_q;

	assign pix.valid          = out_valid_q;
	assign pix.out_red        = out_red_q;
	assign pix.out_green      = out_green_q;
	assign pix.out_blue       = out_blue_q;
	assign pix.out_brightness = out_br_q;

	// advance the sequencer and hold the animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			now_q       <= '0;
			anim_q      <= '0;
			toggle_q    <= '0;
			blink_q     <= 1'b1;
			pending_q   <= 1'b1;
			shown_q     <= 1'b0;
			last_q      <= '0;
			br_q        <= '0;
			up_q        <= '0;
			scale_q     <= '0;
			dvd_q       <= '0;
			dsr_q       <= '0;
			start_q     <= 1'b0;
			short_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_red_q   <= '0;
			out_green_q <= '0;
			out_blue_q  <= '0;
			out_br_q    <= '0;
		end else begin
			start_q     <= 1'b0;
			out_valid_q <= out_valid_q && !pix.ready;

			// a write restarts the animation at the next tick
			if (cfg_hit) begin
				pending_q <= 1'b1;
			end else if (in_beat) begin
				pending_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						now_q <= now_in;
						if (pending_q) begin
							anim_q   <= now_in;
							toggle_q <= now_in;
							blink_q  <= 1'b1;
						end
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					unique case (regs.mode)
						MODE_OFF: begin
							br_q    <= '0;
							state_q <= ST_EMIT;
						end
						MODE_SOLID: begin
							br_q    <= regs.base;
							state_q <= ST_EMIT;
						end
						MODE_BLINK: begin
							if (blink_due) begin
								toggle_q <= now_q;
							end
							blink_q <= blink_next;
							br_q    <= blink_next ? regs.base : '0;
							state_q <= ST_EMIT;
						end
						MODE_BREATHE: begin
							if (half == '0) begin
								scale_q <= FULL_SCALE;
								state_q <= ST_PROD;
							end else begin
								dvd_q   <= DIV_W'(elapsed);
								dsr_q   <= period;
								short_q <= 1'b0;
								start_q <= 1'b1;
								state_q <= ST_MOD;
							end
						end
						default: state_q <= ST_EMIT;
					endcase
				end
				ST_MOD: begin
					if (div_sts.done) begin
						up_q    <= up_next;
						state_q <= ST_RAMP;
					end
				end
				ST_RAMP: begin
					dvd_q   <= DIV_W'(ramp_prod);
					dsr_q   <= half;
					short_q <= 1'b1;
					start_q <= 1'b1;
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					if (div_sts.done) begin
						scale_q <= scale_sat;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: begin
					br_q    <= dim_quo;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// drop repeats, otherwise wait for a free output register
					if (!is_new) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_red_q   <= regs.red;
						out_green_q <= regs.green;
						out_blue_q  <= regs.blue;
						out_br_q    <= br_q;
						last_q      <= key;
						shown_q     <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/led_blink_breathe_animator_unit.sv =====
// Top level of the LED blink and breathe animator.
// Usage:
//   tick : one beat per render tick, carrying now_ms (wrapping milliseconds).
//   pix  : at most one beat per tick, only when colour or brightness changed.
//   cfg  : register writes (index 0 mode .. 5 base brightness), always ready;
//          a write to a listed register restarts the animation at the next tick.
//          Write only while no tick is in flight.
// Throughput: one tick at a time; tick.ready is high only while the
//   sequencer is idle. Off, solid and blink go straight from evaluation to emit.
//   Breathe runs two divides through one shared restoring divider, one
//   quotient bit per cycle: the phase modulo (max(TIME_WIDTH, 24) steps) and
//   the ramp scale (24 steps); the dim by full scale is a single reciprocal
//   step. Both divides are skipped when the period is 1 ms or less.
// Reset: registers return to blink mode, blue, period 500 ms, brightness 64;
//   nothing counts as shown, so the first tick always gives a result.
// Stall: a result waits in the output register; the next tick is taken
//   meanwhile and its result waits in the sequencer until pix is free.
module led_blink_breathe_animator_unit import lbba_pkg::*; #(
	parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	lbba_tick_if.sink   tick,
	lbba_pix_if.source  pix,
	lbba_cfg_if.sink    cfg
);

	localparam int DIV_W = (TIME_WIDTH > SHORT_DIV_W) ? TIME_WIDTH : SHORT_DIV_W;

	cfg_t              regs;
	logic              cfg_hit;
	div_ctl_t          div_ctl;
	div_sts_t          div_sts;
	logic [DIV_W-1:0]  div_dvd;
	logic [DIV_W-1:0]  div_quo;
	logic [RATE_W-1:0] div_dsr;
	logic [RATE_W-1:0] div_rem;

	// register file
	lbba_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.regs    (regs),
		.cfg_hit (cfg_hit)
	);

	// shared divider
	lbba_div #(
		.DIV_W (DIV_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_ctl (div_ctl),
		.div_dvd (div_dvd),
		.div_dsr (div_dsr),
		.div_sts (div_sts),
		.div_quo (div_quo),
		.div_rem (div_rem)
	);

	// tick sequencer and output register
	lbba_seq #(
		.TIME_WIDTH (TIME_WIDTH),
		.DIV_W      (DIV_W)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.tick    (tick),
		.pix     (pix),
		.regs    (regs),
		.cfg_hit (cfg_hit),
		.div_ctl (div_ctl),
		.div_dvd (div_dvd),
		.div_dsr (div_dsr),
		.div_sts (div_sts),
		.div_quo (div_quo),
		.div_rem (div_rem)
	);

endmodule
